// ----- rtl/crmc_pkg.sv -----
// ----------------------------------------------------------------------------
// crmc_pkg: shared types and constants for the capture rectangle classifier
// Rectangle layouts, result status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package crmc_pkg;

    localparam int COORD_W      = 16;
    localparam int RECT_W       = 4 * COORD_W;
    localparam int NUM_RECT_REGS = 4;
    localparam int MAX_MONITORS_DEF = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int COUNT_W      = 3;
    localparam int MON_IDX_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MON_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_RECT0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_RECT1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_RECT2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MON_RECT3  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTIAL    = 3'd5;

    // Result status codes; minimized through cross are in priority order
    typedef enum logic [2:0] {
        ST_READY      = 3'd0,
        ST_MINIMIZED  = 3'd1,
        ST_HIDDEN     = 3'd2,
        ST_INVALID    = 3'd3,
        ST_NO_MONITOR = 3'd4,
        ST_OFFSCREEN  = 3'd5,
        ST_CROSS      = 3'd6,
        ST_PARTIAL    = 3'd7
    } t_status;

    // Signed rectangle, left edge in the low bits (matches the register packing)
    typedef struct packed {
        logic signed [COORD_W-1:0] b;
        logic signed [COORD_W-1:0] r;
        logic signed [COORD_W-1:0] t;
        logic signed [COORD_W-1:0] l;
    } t_rect;

    // Rectangle relative to a monitor origin
    typedef struct packed {
        logic [COORD_W-1:0] b;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] t;
        logic [COORD_W-1:0] l;
    } t_src;

    // One request word
    typedef struct packed {
        t_rect rect;
        logic  minimized;
        logic  hidden;
    } t_req;

    // Clip of the request against one monitor
    typedef struct packed {
        logic  hit;
        t_rect vis;
        t_src  src;
    } t_clip;

    // One result word
    typedef struct packed {
        t_status              status;
        logic [MON_IDX_W-1:0] monitor_index;
        logic                 full_vis;
        t_rect                vis;
        t_src                 src;
    } t_result;

endpackage

// ----- rtl/crmc_ifs.sv -----
// ----------------------------------------------------------------------------
// crmc_ifs: channel interfaces of the capture rectangle classifier
// Request channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Request channel
interface crmc_req_if
    import crmc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] req_left;
    logic signed [COORD_W-1:0] req_top;
    logic signed [COORD_W-1:0] req_right;
    logic signed [COORD_W-1:0] req_bottom;
    logic                      is_minimized;
    logic                      is_hidden;

    modport source (
        output valid, req_left, req_top, req_right, req_bottom, is_minimized, is_hidden,
        input  ready
    );
    modport sink (
        input  valid, req_left, req_top, req_right, req_bottom, is_minimized, is_hidden,
        output ready
    );
endinterface

// Result channel
interface crmc_res_if
    import crmc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [MON_IDX_W-1:0]      monitor_index;
    logic                      full_vis;
    logic signed [COORD_W-1:0] vis_left;
    logic signed [COORD_W-1:0] vis_top;
    logic signed [COORD_W-1:0] vis_right;
    logic signed [COORD_W-1:0] vis_bottom;
    logic [COORD_W-1:0]        src_left;
    logic [COORD_W-1:0]        src_top;
    logic [COORD_W-1:0]        src_right;
    logic [COORD_W-1:0]        src_bottom;

    modport source (
        output valid, status, monitor_index, full_vis,
               vis_left, vis_top, vis_right, vis_bottom,
               src_left, src_top, src_right, src_bottom,
        input  ready
    );
    modport sink (
        input  valid, status, monitor_index, full_vis,
               vis_left, vis_top, vis_right, vis_bottom,
               src_left, src_top, src_right, src_bottom,
        output ready
    );
endinterface

// Configuration write channel
interface crmc_cfg_if
    import crmc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [RECT_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/crmc_clip.sv -----
// ----------------------------------------------------------------------------
// crmc_clip: clip the request against one monitor rectangle
// Intersection, positive-area test and monitor-relative coordinates.
// ----------------------------------------------------------------------------
module crmc_clip
    import crmc_pkg::*;
(
    input  t_rect i_req,
    input  t_rect i_mon,
    output t_clip o_clip
);

    t_rect c;

    // Intersection edges
    always_comb begin
        c.l = (i_req.l > i_mon.l) ? i_req.l : i_mon.l;
        c.t = (i_req.t > i_mon.t) ? i_req.t : i_mon.t;
        c.r = (i_req.r < i_mon.r) ? i_req.r : i_mon.r;
        c.b = (i_req.b < i_mon.b) ? i_req.b : i_mon.b;
    end

    // Overlap counts only with positive width and height; an empty monitor never hits
    assign o_clip.hit   = (c.r > c.l) && (c.b > c.t);
    assign o_clip.vis   = c;
    assign o_clip.src.l = COORD_W'(c.l - i_mon.l);
    assign o_clip.src.t = COORD_W'(c.t - i_mon.t);
    assign o_clip.src.r = COORD_W'(c.r - i_mon.l);
    assign o_clip.src.b = COORD_W'(c.b - i_mon.t);

endmodule

// ----- rtl/crmc_classify.sv -----
// ----------------------------------------------------------------------------
// crmc_classify: priority classification of one clipped request
// Picks the single overlapping monitor and builds the result word.
// ----------------------------------------------------------------------------
module crmc_classify
    import crmc_pkg::*;
#(
    parameter int MAX_MONITORS = MAX_MONITORS_DEF
) (
    input  t_req                     i_req,
    input  t_clip [MAX_MONITORS-1:0] i_clip,
    input  logic [COUNT_W-1:0]       i_mon_count,
    input  logic                     i_partial,
    output t_result                  o_result
);

    localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MAX_MONITORS);

    logic [COUNT_W-1:0]   cnt;
    logic                 found;
    logic                 multi;
    logic [MON_IDX_W-1:0] sel;
    t_clip                pick;
    logic                 req_ok;
    logic                 full;

    // Monitors in use, count saturated at the lane count
    assign cnt    = (i_mon_count > MaxCnt) ? MaxCnt : i_mon_count;
    assign req_ok = (i_req.rect.r > i_req.rect.l) && (i_req.rect.b > i_req.rect.t);

    // First hit and multi-hit detection across lanes
    always_comb begin
        found = 1'b0;
        multi = 1'b0;
        sel   = '0;
        pick  = '0;
        for (int i = 0; i < MAX_MONITORS; i++) begin
            if (i_clip[i].hit && (COUNT_W'(i) < cnt)) begin
                if (found) begin
                    multi = 1'b1;
                end else begin
                    found = 1'b1;
                    sel   = MON_IDX_W'(i);
                    pick  = i_clip[i];
                end
            end
        end
    end

    assign full = (pick.vis == i_req.rect);

    // Status priority; early statuses leave all other fields zero
    always_comb begin
        o_result = '0;
        if (i_req.minimized) begin
            o_result.status = ST_MINIMIZED;
        end else if (i_req.hidden) begin
            o_result.status = ST_HIDDEN;
        end else if (!req_ok) begin
            o_result.status = ST_INVALID;
        end else if (cnt == '0) begin
            o_result.status = ST_NO_MONITOR;
        end else if (!found) begin
            o_result.status = ST_OFFSCREEN;
        end else if (multi) begin
            o_result.status = ST_CROSS;
        end else begin
            o_result.status        = (!full && i_partial) ? ST_PARTIAL : ST_READY;
            o_result.monitor_index = sel;
            o_result.full_vis      = full;
            o_result.vis           = pick.vis;
            o_result.src           = pick.src;
        end
    end

endmodule

// ----- rtl/capture_rect_monitor_classifier_core.sv -----
// ----------------------------------------------------------------------------
// capture_rect_monitor_classifier_core: capture rectangle monitor classifier
// Clips a requested rectangle against configured monitors and classifies it.
// ----------------------------------------------------------------------------
// One request word is accepted per clock while ready is high; its result word
// passes through the input register, then the result register, with the clip
// lanes for all monitors working in parallel between the two registers. A
// stalled result register holds its word while the input register may still
// take one more; ready drops only when both are full. Configuration is written
// through the cfg channel (always ready): index 0 monitor count, 1..4 monitor
// rectangles packed as left/top/right/bottom signed 16-bit fields from the low
// bits, 5 partial policy. Writes to other indexes are ignored. The user must
// write it only while no word is in flight; the block does not enforce this.
module capture_rect_monitor_classifier_core
    import crmc_pkg::*;
#(
    parameter int MAX_MONITORS = MAX_MONITORS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    crmc_req_if.sink          i_req,
    crmc_res_if.source        o_res,
    crmc_cfg_if.sink          i_cfg
);

    // Configuration registers
    logic [COUNT_W-1:0]                   r_mon_count;
    logic [NUM_RECT_REGS-1:0][RECT_W-1:0] r_mon_rect;
    logic                                 r_partial;
    logic [MON_IDX_W-1:0]                 rect_sel;

    // Pipeline registers
    logic    r_s1_valid;
    t_req    r_s1_req;
    logic    r_out_valid;
    t_result r_out;
    logic    n_s1_valid;
    logic    n_out_valid;
    logic    out_load;
    logic    in_ready;

    t_clip [MAX_MONITORS-1:0] clip;
    t_result                  result;

    assign i_cfg.ready = 1'b1;
    assign rect_sel    = MON_IDX_W'(i_cfg.index - CFG_MON_RECT0);

    // Configuration write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mon_count <= '0;
            r_mon_rect  <= '0;
            r_partial   <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index) inside
                CFG_MON_COUNT: begin
                    r_mon_count <= i_cfg.data[COUNT_W-1:0];
                end
                CFG_MON_RECT0, CFG_MON_RECT1, CFG_MON_RECT2, CFG_MON_RECT3: begin
                    r_mon_rect[rect_sel] <= i_cfg.data;
                end
                CFG_PARTIAL: begin
                    r_partial <= i_cfg.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: result register loads when empty or being taken
    always_comb begin
        out_load    = !r_out_valid || o_res.ready;
        in_ready    = !r_s1_valid || out_load;
        n_s1_valid  = in_ready ? i_req.valid : r_s1_valid;
        n_out_valid = out_load ? r_s1_valid : r_out_valid;
    end

    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Input word register
    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_s1_req.rect.l    <= i_req.req_left;
            r_s1_req.rect.t    <= i_req.req_top;
            r_s1_req.rect.r    <= i_req.req_right;
            r_s1_req.rect.b    <= i_req.req_bottom;
            r_s1_req.minimized <= i_req.is_minimized;
            r_s1_req.hidden    <= i_req.is_hidden;
        end
    end

    // One clip lane per monitor
    for (genvar g = 0; g < MAX_MONITORS; g++) begin : g_lane
        crmc_clip u_clip (
            .i_req  (r_s1_req.rect),
            .i_mon  (t_rect'(r_mon_rect[g])),
            .o_clip (clip[g])
        );
    end

    crmc_classify #(
        .MAX_MONITORS (MAX_MONITORS)
    ) u_classify (
        .i_req       (r_s1_req),
        .i_clip      (clip),
        .i_mon_count (r_mon_count),
        .i_partial   (r_partial),
        .o_result    (result)
    );

    // Result word register
    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_out <= result;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.monitor_index = r_out.monitor_index;
    assign o_res.full_vis      = r_out.full_vis;
    assign o_res.vis_left      = r_out.vis.l;
    assign o_res.vis_top       = r_out.vis.t;
    assign o_res.vis_right     = r_out.vis.r;
    assign o_res.vis_bottom    = r_out.vis.b;
    assign o_res.src_left      = r_out.src.l;
    assign o_res.src_top       = r_out.src.t;
    assign o_res.src_right     = r_out.src.r;
    assign o_res.src_bottom    = r_out.src.b;

    // Early statuses carry no geometry
    a_early_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_READY && r_out.status != ST_PARTIAL)
        |-> (r_out.monitor_index == '0 && !r_out.full_vis
             && r_out.vis == '0 && r_out.src == '0))
        else $error("early status with nonzero fields");

    // Fully visible words are never flagged partial
    a_full_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.full_vis) |-> (r_out.status == ST_READY))
        else $error("fully visible word without ready status");

    // A clipped ready word only happens when the partial policy bit is clear
    a_partial_policy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_READY && !r_out.full_vis) |-> !r_partial)
        else $error("partial word reported as ready");

    // Input backpressure only when both registers hold words
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_valid && r_out_valid && !o_res.ready))
        else $error("input stalled with room in the pipeline");

endmodule
